/* rtl/chf_pkg.sv */
// Package: constants, types and arctangent table for the compass heading pipeline.
package chf_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

    localparam int FIELD_W = 13;
    localparam int FRAC    = 16;
    localparam int XW      = 32;
    localparam int ZW      = 34;
    localparam int AW      = ZW - FRAC;
    localparam int HW      = 19;
    localparam int OUT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 5;

    localparam int FULL_TURN    = 46080;
    localparam int HALF_TURN    = 23040;
    localparam int QUARTER_TURN = 11520;

    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(HALF_TURN * (1 << FRAC));
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(QUARTER_TURN * (1 << FRAC));
    localparam logic signed [ZW-1:0] Z_ROUND   = ZW'(1 << (FRAC - 1));
    localparam logic signed [HW-1:0] H_FULL    = HW'(FULL_TURN);
    localparam logic signed [HW-1:0] H_HALF    = HW'(HALF_TURN);

    localparam logic REG_DECLINATION = 1'b0;
    localparam logic REG_ZERO_REF    = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 hold;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(377487360);
            5'd1:    v = ZW'(222843801);
            5'd2:    v = ZW'(117744544);
            5'd3:    v = ZW'(59768969);
            5'd4:    v = ZW'(30000467);
            5'd5:    v = ZW'(15014858);
            5'd6:    v = ZW'(7509261);
            5'd7:    v = ZW'(3754860);
            5'd8:    v = ZW'(1877459);
            5'd9:    v = ZW'(938733);
            5'd10:   v = ZW'(469367);
            5'd11:   v = ZW'(234683);
            5'd12:   v = ZW'(117342);
            5'd13:   v = ZW'(58671);
            5'd14:   v = ZW'(29335);
            5'd15:   v = ZW'(14668);
            5'd16:   v = ZW'(7334);
            5'd17:   v = ZW'(3667);
            5'd18:   v = ZW'(1833);
            5'd19:   v = ZW'(917);
            5'd20:   v = ZW'(458);
            5'd21:   v = ZW'(229);
            5'd22:   v = ZW'(115);
            5'd23:   v = ZW'(57);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/chf_prep.sv */
// Input stage: axis special cases, left half plane fold and CORDIC seed.
module chf_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [chf_pkg::FIELD_W-1:0]   field_x,
    input  logic signed [chf_pkg::FIELD_W-1:0]   field_y,
    output chf_pkg::cordic_t                     seed_reg
);

    chf_pkg::cordic_t                  seed_next;
    logic signed [chf_pkg::XW-1:0]     xe;
    logic signed [chf_pkg::XW-1:0]     ye;

    always_comb
    begin
        xe = chf_pkg::XW'(field_x) <<< chf_pkg::FRAC;
        ye = chf_pkg::XW'(field_y) <<< chf_pkg::FRAC;
        seed_next.valid = in_valid;
        seed_next.hold  = 1'b0;
        seed_next.x     = xe;
        seed_next.y     = ye;
        seed_next.z     = '0;
        if (field_y == '0)
        begin
            seed_next.hold = 1'b1;
            seed_next.z    = field_x[chf_pkg::FIELD_W-1] ? chf_pkg::Z_HALF : '0;
        end
        else if (field_x == '0)
        begin
            seed_next.hold = 1'b1;
            seed_next.z    = field_y[chf_pkg::FIELD_W-1] ? -chf_pkg::Z_QUARTER
                                                         : chf_pkg::Z_QUARTER;
        end
        else if (field_x[chf_pkg::FIELD_W-1])
        begin
            seed_next.x = -xe;
            seed_next.y = -ye;
            seed_next.z = field_y[chf_pkg::FIELD_W-1] ? -chf_pkg::Z_HALF : chf_pkg::Z_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (en)
            seed_reg <= seed_next;
    end

endmodule

/* rtl/chf_cell.sv */
// One vectoring CORDIC micro-rotation cell of the pipeline.
module chf_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [chf_pkg::IDX_W-1:0]    stage_idx,
    input  chf_pkg::cordic_t             cur,
    output chf_pkg::cordic_t             out_reg
);

    chf_pkg::cordic_t                  out_next;
    logic signed [chf_pkg::XW-1:0]     xs;
    logic signed [chf_pkg::XW-1:0]     ys;
    logic signed [chf_pkg::ZW-1:0]     ang;

    always_comb
    begin
        xs       = cur.x >>> stage_idx;
        ys       = cur.y >>> stage_idx;
        ang      = chf_pkg::atan_entry(stage_idx);
        out_next = cur;
        if (!cur.hold)
        begin
            if (!cur.y[chf_pkg::XW-1])
            begin
                out_next.x = cur.x + ys;
                out_next.y = cur.y - xs;
                out_next.z = cur.z + ang;
            end
            else
            begin
                out_next.x = cur.x - ys;
                out_next.y = cur.y + xs;
                out_next.z = cur.z - ang;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_reg <= '0;
        else if (en)
            out_reg <= out_next;
    end

    // exact axis angles must pass through untouched
    a_hold_passes: assert property (@(posedge clk) disable iff (!rst_n)
        en && cur.valid && cur.hold |=> out_reg.hold && out_reg.z == $past(cur.z))
        else $error("held angle changed in CORDIC cell");

endmodule

/* rtl/chf_post.sv */
// Output stages: rounding, declination and zero reference wraps, half turn offset.
module chf_post (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  chf_pkg::cordic_t                     res,
    input  logic signed [chf_pkg::CFG_W-1:0]     declination,
    input  logic [chf_pkg::CFG_W-1:0]            zero_reference,
    output logic                                 out_valid,
    output logic signed [chf_pkg::OUT_W-1:0]     heading
);

    logic signed [chf_pkg::ZW-1:0]     zr;
    logic signed [chf_pkg::AW-1:0]     rnd;
    logic signed [chf_pkg::HW-1:0]     a_sum;
    logic signed [chf_pkg::HW-1:0]     a_next;
    logic signed [chf_pkg::HW-1:0]     a_reg;
    logic                              va_reg;
    logic signed [chf_pkg::HW-1:0]     b_sum;
    logic signed [chf_pkg::HW-1:0]     b_wrap;
    logic signed [chf_pkg::HW-1:0]     c_val;
    logic signed [chf_pkg::OUT_W-1:0]  heading_next;
    logic signed [chf_pkg::OUT_W-1:0]  heading_reg;
    logic                              vb_reg;

    always_comb
    begin
        zr    = res.z + chf_pkg::Z_ROUND;
        rnd   = zr[chf_pkg::ZW-1:chf_pkg::FRAC];
        a_sum = chf_pkg::HW'(rnd) + chf_pkg::HW'(declination);
        if (a_sum < 0)
            a_next = a_sum + chf_pkg::H_FULL;
        else if (a_sum > chf_pkg::H_FULL)
            a_next = a_sum - chf_pkg::H_FULL;
        else
            a_next = a_sum;

        b_sum = a_reg - $signed({{(chf_pkg::HW-chf_pkg::CFG_W){1'b0}}, zero_reference});
        if (b_sum < 0)
            b_wrap = b_sum + chf_pkg::H_FULL;
        else if (b_sum > chf_pkg::H_FULL)
            b_wrap = b_sum - chf_pkg::H_FULL;
        else
            b_wrap = b_sum;
        c_val        = b_wrap - chf_pkg::H_HALF;
        heading_next = c_val[chf_pkg::OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            a_reg       <= '0;
            heading_reg <= '0;
        end
        else if (en)
        begin
            va_reg      <= res.valid;
            vb_reg      <= va_reg;
            a_reg       <= a_next;
            heading_reg <= heading_next;
        end
    end

    assign out_valid = vb_reg;
    assign heading   = heading_reg;

endmodule

/* rtl/compass_heading_from_field_core.sv */
// Top level: compass heading pipeline with configuration registers.
// Pipeline: seed register, one register per CORDIC cell, then the a_reg and heading_reg output stages.
// Throughput: one request per cycle while the output is not stalled; every cell is its own register stage.
// A stalled output freezes the whole pipeline, and s_tready drops with it.
// Reset clears all valid bits and sets declination and zero_reference to 0.
module compass_heading_from_field_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // field_x[12:0], field_y[25:13], zero pad
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // heading[15:0]
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [chf_pkg::CFG_W-1:0]        cfg_data
);

    logic                                    en;
    logic signed [chf_pkg::CFG_W-1:0]        decl_reg;
    logic [chf_pkg::CFG_W-1:0]               zref_reg;
    chf_pkg::cordic_t                        chain [0:chf_pkg::NUM_CELLS];
    logic signed [chf_pkg::OUT_W-1:0]        heading;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decl_reg <= '0;
            zref_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                chf_pkg::REG_DECLINATION: decl_reg <= cfg_data;
                chf_pkg::REG_ZERO_REF:    zref_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    chf_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .field_x  ($signed(s_tdata[12:0])),
        .field_y  ($signed(s_tdata[25:13])),
        .seed_reg (chain[0])
    );

    for (genvar i = 0; i < chf_pkg::NUM_CELLS; i++)
    begin : g_cell
        chf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_idx (chf_pkg::IDX_W'(i)),
            .cur       (chain[i]),
            .out_reg   (chain[i+1])
        );
    end

    chf_post u_post (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .res            (chain[chf_pkg::NUM_CELLS]),
        .declination    (decl_reg),
        .zero_reference (zref_reg),
        .out_valid      (m_tvalid),
        .heading        (heading)
    );

    assign m_tdata = heading;

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tdata[12:0] == '0 && s_tdata[25:13] == '0
        |=> chain[0].valid && chain[0].hold && chain[0].z == '0)
        else $error("zero vector not seeded as zero angle");

endmodule
